FILE: rtl/dsc_pkg.sv
// package: types, codes and channel helper functions of the dual serial controller
package dsc_pkg;

  localparam int unsigned RX_FIFO_DEPTH = 3;
  localparam int unsigned CNT_W = $clog2(RX_FIFO_DEPTH + 1);

  // pending flag bits
  localparam int unsigned PF_TX  = 0;
  localparam int unsigned PF_EXT = 1;
  localparam int unsigned PF_ARM = 2;

  typedef enum logic [2:0] {
    KIND_READ    = 3'd0,
    KIND_WRITE   = 3'd1,
    KIND_RX      = 3'd2,
    KIND_TX_DONE = 3'd3,
    KIND_MODEM   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    PORT_CMD_B  = 3'd0,
    PORT_CMD_A  = 3'd1,
    PORT_DATA_B = 3'd2,
    PORT_DATA_A = 3'd3,
    PORT_ENH_B  = 3'd4,
    PORT_ENH_A  = 3'd5
  } port_e;

  // register pointer values
  localparam logic [3:0] RP_CMD  = 4'd0;
  localparam logic [3:0] RP_1    = 4'd1;
  localparam logic [3:0] RP_IVEC = 4'd2;
  localparam logic [3:0] RP_3    = 4'd3;
  localparam logic [3:0] RP_4    = 4'd4;
  localparam logic [3:0] RP_5    = 4'd5;
  localparam logic [3:0] RP_DATA = 4'd8;
  localparam logic [3:0] RP_MIC  = 4'd9;
  localparam logic [3:0] RP_15   = 4'd15;

  // wr0 command field, bits 5:3
  localparam logic [2:0] CMD_POINT_HIGH = 3'd1;
  localparam logic [2:0] CMD_RESET_EXT  = 3'd2;
  localparam logic [2:0] CMD_ARM_RX     = 3'd4;
  localparam logic [2:0] CMD_RESET_TX   = 3'd5;
  localparam logic [2:0] CMD_ERR_RESET  = 3'd6;

  // wr9 reset field, bits 7:6
  localparam logic [1:0] RST_CH_B = 2'd1;
  localparam logic [1:0] RST_CH_A = 2'd2;
  localparam logic [1:0] RST_HW   = 2'd3;

  // configuration register index
  localparam logic CFG_IRQ_SHARED = 1'b0;

  typedef struct packed {
    logic [7:0]                        w1;
    logic [7:0]                        w3;
    logic [7:0]                        w5;
    logic [7:0]                        w15;
    logic [7:0]                        rr0;
    logic [7:0]                        rr1;
    logic [7:0]                        rr8;
    logic [RX_FIFO_DEPTH-1:0][7:0]     fifo;
    logic [CNT_W-1:0]                  cnt;
    logic [2:0]                        pend;
    logic                              enh;
  } ch_t;

  // channel state after hardware reset
  localparam ch_t CH_RESET = '{w1: 8'h00, w3: 8'h00, w5: 8'h00, w15: 8'hF8,
                               rr0: 8'h44, rr1: 8'h07, rr8: 8'h00, fifo: '0,
                               cnt: '0, pend: 3'b100, enh: 1'b0};

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] port;
    logic       channel;
    logic [7:0] data_in;
    logic       line_connected;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line_a;
    logic       irq_line_b;
    logic       tx_strobe;
    logic [7:0] tx_byte;
    logic       tx_channel;
    logic       rx_enabled_a;
    logic       rx_enabled_b;
  } res_t;

  function automatic ch_t chan_reset(ch_t c);
    ch_t r;
    r      = c;
    r.cnt  = '0;
    r.pend = 3'b100;
    r.w1   = c.w1 & 8'h24;
    r.w3   = c.w3 & 8'hFE;
    r.w5   = c.w5 & 8'h61;
    r.w15  = 8'hF8;
    r.rr0  = (c.rr0 & 8'h38) | 8'h44;
    r.rr1  = 8'h07;
    return r;
  endfunction

  function automatic logic [2:0] irq_bits(ch_t c);
    logic [1:0] mode;
    logic       special;
    logic       have;
    logic [2:0] b;
    mode    = c.w1[4:3];
    special = c.rr1[6:4] != 3'd0;
    have    = c.cnt != '0;
    b[0]    = c.pend[PF_EXT] & c.w1[0];
    b[1]    = c.pend[PF_TX] & c.w1[1] & c.w5[3];
    b[2]    = c.w3[0] & ((special && mode != 2'b00) ||
              (have && (mode == 2'b10 || (mode == 2'b01 && c.pend[PF_ARM]))));
    return b;
  endfunction

  // receive fifo pop, head value taken by the caller
  function automatic ch_t chan_pop(ch_t c);
    ch_t r;
    r = c;
    if (c.cnt != '0) begin
      for (int i = 0; i < int'(RX_FIFO_DEPTH) - 1; i++) begin
        r.fifo[i] = c.fifo[i+1];
      end
      r.cnt = c.cnt - CNT_W'(1);
    end
    r.rr0[0]      = 1'b0;
    r.rr8         = (c.cnt != '0) ? c.fifo[0] : 8'h00;
    r.pend[PF_ARM] = 1'b0;
    return r;
  endfunction

  function automatic ch_t chan_push_tx(ch_t c);
    ch_t r;
    r             = c;
    r.pend[PF_TX] = 1'b0;
    r.rr0[2]      = 1'b0;
    r.rr1[0]      = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/dsc_item_if.sv
// interface: input item channel with valid/ready handshake
interface dsc_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [2:0] port;
  logic       channel;
  logic [7:0] data_in;
  logic       line_connected;

  modport source (output valid, kind, port, channel, data_in, line_connected, input ready);
  modport sink (input valid, kind, port, channel, data_in, line_connected, output ready);
endinterface

FILE: rtl/dsc_result_if.sv
// interface: result channel with valid/ready handshake
interface dsc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_line_a;
  logic       irq_line_b;
  logic       tx_strobe;
  logic [7:0] tx_byte;
  logic       tx_channel;
  logic       rx_enabled_a;
  logic       rx_enabled_b;

  modport source (output valid, read_data, irq_line_a, irq_line_b, tx_strobe, tx_byte,
                  tx_channel, rx_enabled_a, rx_enabled_b, input ready);
  modport sink (input valid, read_data, irq_line_a, irq_line_b, tx_strobe, tx_byte,
                tx_channel, rx_enabled_a, rx_enabled_b, output ready);
endinterface

FILE: rtl/dsc_core.sv
// controller state and the per-transaction update logic
module dsc_core import dsc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  item_t item_i,
  input  logic  irq_shared_i,
  output res_t  res_o
);

  ch_t        ch_q [2];
  ch_t        ch_d [2];
  logic [3:0] ptr_q, ptr_d;
  logic [7:0] ivec_q, ivec_d;
  logic       mie_q, mie_d;

  ch_t        cn;
  logic       tc;
  logic       rst_a, rst_b, rst_hw;
  logic [7:0] rd;
  logic       tx_fire;
  logic [7:0] tx_val;
  logic [7:0] d;
  logic [7:0] cur;
  logic [7:0] lines;
  logic       ia, ib;

  always_comb begin
    d       = item_i.data_in;
    tc      = (kind_e'(item_i.kind) == KIND_READ || kind_e'(item_i.kind) == KIND_WRITE)
              ? ~item_i.port[0] : item_i.channel;
    cn      = tc ? ch_q[1] : ch_q[0];
    ptr_d   = ptr_q;
    ivec_d  = ivec_q;
    mie_d   = mie_q;
    rst_a   = 1'b0;
    rst_b   = 1'b0;
    rst_hw  = 1'b0;
    rd      = 8'h00;
    tx_fire = 1'b0;
    tx_val  = 8'h00;
    cur     = 8'h00;
    lines   = 8'h00;
    case (kind_e'(item_i.kind))
      KIND_READ: begin
        case (port_e'(item_i.port))
          PORT_CMD_B, PORT_CMD_A: begin
            ptr_d = RP_CMD;
            case (ptr_q)
              RP_3: rd = tc ? 8'h00 : {2'b00, irq_bits(ch_q[0]), irq_bits(ch_q[1])};
              RP_IVEC: rd = ivec_q;
              RP_CMD: begin
                cn.rr0[0] = cn.w3[0] && (cn.cnt != '0);
                rd        = cn.rr0;
              end
              RP_DATA: begin
                rd = (cn.cnt != '0) ? cn.fifo[0] : 8'h00;
                cn = chan_pop(cn);
              end
              RP_1: rd = cn.rr1;
              default: rd = 8'h00;
            endcase
          end
          PORT_DATA_B, PORT_DATA_A: begin
            rd = (cn.cnt != '0) ? cn.fifo[0] : 8'h00;
            cn = chan_pop(cn);
          end
          PORT_ENH_B, PORT_ENH_A: rd = {3'b000, cn.enh, 4'h0};
          default: rd = 8'h00;
        endcase
      end
      KIND_WRITE: begin
        case (port_e'(item_i.port))
          PORT_CMD_B, PORT_CMD_A: begin
            ptr_d = RP_CMD;
            case (ptr_q)
              RP_CMD: begin
                ptr_d = {1'b0, d[2:0]};
                case (d[5:3])
                  CMD_POINT_HIGH: ptr_d[3] = 1'b1;
                  CMD_RESET_EXT:  cn.pend[PF_EXT] = 1'b0;
                  CMD_ARM_RX:     cn.pend[PF_ARM] = 1'b1;
                  CMD_RESET_TX:   cn.pend[PF_TX] = 1'b0;
                  CMD_ERR_RESET:  cn.rr1[6:4] = 3'b000;
                  default: ;
                endcase
              end
              RP_IVEC: ivec_d = d;
              RP_MIC: begin
                case (d[7:6])
                  RST_CH_B: rst_b = 1'b1;
                  RST_CH_A: rst_a = 1'b1;
                  RST_HW:   rst_hw = 1'b1;
                  default: ;
                endcase
                mie_d = d[3];
              end
              RP_1: begin
                if (d[1] && !cn.w1[1] && cn.rr0[2]) cn.pend[PF_TX] = 1'b1;
                if ((d[4:3] ^ cn.w1[4:3]) != 2'b00) cn.pend[PF_ARM] = 1'b1;
                cn.w1 = d;
              end
              RP_3: begin
                cur = cn.w3;
                if (cur[4] != d[4]) begin
                  cur[4]    = 1'b1;
                  cn.rr0[4] = 1'b1;
                end
                if (cur[0] != d[0]) begin
                  cur[0] = d[0];
                  if (!d[0]) begin
                    cur[4]    = 1'b1;
                    cn.rr0[4] = 1'b1;
                  end
                end
                cn.w3 = (cur & 8'h11) | (d & 8'hEE);
              end
              RP_4: begin
                if (d[3:2] == 2'b00 && d[5:4] == 2'b10 && !cn.w3[0]) cn.rr0[4] = 1'b1;
              end
              RP_5: cn.w5 = d;
              RP_DATA: begin
                tx_fire = 1'b1;
                tx_val  = d;
                cn      = chan_push_tx(cn);
              end
              RP_15: cn.w15 = d;
              default: ;
            endcase
          end
          PORT_DATA_B, PORT_DATA_A: begin
            tx_fire = 1'b1;
            tx_val  = d;
            cn      = chan_push_tx(cn);
          end
          PORT_ENH_B, PORT_ENH_A: cn.enh = d[4];
          default: ;
        endcase
      end
      KIND_RX: begin
        if (cn.w3[0]) begin
          if (cn.cnt < CNT_W'(RX_FIFO_DEPTH)) begin
            for (int i = 0; i < int'(RX_FIFO_DEPTH); i++) begin
              if (cn.cnt == CNT_W'(i)) cn.fifo[i] = d;
            end
            cn.cnt = cn.cnt + CNT_W'(1);
          end else begin
            cn.rr1[5] = 1'b1;
          end
        end
      end
      KIND_TX_DONE: begin
        if (!cn.rr0[2]) begin
          cn.rr0[2]      = 1'b1;
          cn.rr1[0]      = 1'b1;
          cn.pend[PF_TX] = 1'b1;
        end
      end
      KIND_MODEM: begin
        lines = item_i.line_connected ? 8'h28 : 8'h00;
        if (((cn.rr0 ^ lines) & cn.w15 & 8'h28) != 8'h00) cn.pend[PF_EXT] = 1'b1;
        cn.rr0 = (cn.rr0 & 8'hD7) | lines;
      end
      default: ;
    endcase

    ch_d[0] = tc ? ch_q[0] : cn;
    ch_d[1] = tc ? cn : ch_q[1];
    if (rst_hw) begin
      ch_d[0] = chan_reset(ch_d[0]);
      ch_d[1] = chan_reset(ch_d[1]);
    end
    if (rst_a) ch_d[0] = chan_reset(ch_d[0]);
    if (rst_b) ch_d[1] = chan_reset(ch_d[1]);

    ia = mie_d && (irq_bits(ch_d[0]) != 3'b000);
    ib = mie_d && (irq_bits(ch_d[1]) != 3'b000);

    res_o.read_data    = rd;
    res_o.irq_line_a   = irq_shared_i ? (ia | ib) : ia;
    res_o.irq_line_b   = irq_shared_i ? 1'b0 : ib;
    res_o.tx_strobe    = tx_fire;
    res_o.tx_byte      = tx_val;
    res_o.tx_channel   = tx_fire & tc;
    res_o.rx_enabled_a = ch_d[0].w3[0];
    res_o.rx_enabled_b = ch_d[1].w3[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        ch_q[c] <= CH_RESET;
      end
      ptr_q  <= '0;
      ivec_q <= '0;
      mie_q  <= 1'b0;
    end else if (en_i) begin
      ch_q[0] <= ch_d[0];
      ch_q[1] <= ch_d[1];
      ptr_q   <= ptr_d;
      ivec_q  <= ivec_d;
      mie_q   <= mie_d;
    end
  end

endmodule

FILE: rtl/dual_serial_controller_regs.sv
// top level: dual serial controller register model with item, result and apb ports
// Two-channel serial controller register model. Each transaction on the item channel
// (bus read or write through the six ports, received byte, transmit done, modem line
// update) produces exactly one result transaction carrying read data, both interrupt
// levels, a transmit strobe with its byte and channel, and the receiver enable bits.
// An item is captured in an input register, processed by the update logic and written
// to a result register, so one item can be taken every clock; the result register
// stalls the pipe only while a result waits and the sink holds ready low. The only
// configuration register, irq_shared, sits at apb byte address 0 and should be
// written while idle.
module dual_serial_controller_regs import dsc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  dsc_item_if.sink      in_if,
  dsc_result_if.source  out_if,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  item_t item_q;
  logic  item_valid_q;
  res_t  res_d, res_q;
  logic  out_valid_q;
  logic  irq_shared_q;
  logic  advance;

  // item moves on when the result register is free or being drained
  assign advance     = item_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !item_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      item_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      item_q.kind           <= in_if.kind;
      item_q.port           <= in_if.port;
      item_q.channel        <= in_if.channel;
      item_q.data_in        <= in_if.data_in;
      item_q.line_connected <= in_if.line_connected;
    end
  end

  dsc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .item_i       (item_q),
    .irq_shared_i (irq_shared_q),
    .res_o        (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.read_data    = res_q.read_data;
  assign out_if.irq_line_a   = res_q.irq_line_a;
  assign out_if.irq_line_b   = res_q.irq_line_b;
  assign out_if.tx_strobe    = res_q.tx_strobe;
  assign out_if.tx_byte      = res_q.tx_byte;
  assign out_if.tx_channel   = res_q.tx_channel;
  assign out_if.rx_enabled_a = res_q.rx_enabled_a;
  assign out_if.rx_enabled_b = res_q.rx_enabled_b;

  // apb configuration register, pready tied high
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_shared_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == CFG_IRQ_SHARED) begin
      irq_shared_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == CFG_IRQ_SHARED) ? {31'b0, irq_shared_q} : 32'b0;

endmodule

FILE: tb/dsc_tb_item_if.sv
// interfaces are taken from the rtl; this file holds the testbench item record type
`timescale 1ns / 1ps
package dsc_tb_pkg;
  import dsc_pkg::*;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] port;
    logic       channel;
    logic [7:0] data_in;
    logic       line_connected;
  } stim_t;
endpackage

FILE: tb/dsc_checker.sv
// checker: predicts serial controller results from accepted transactions and compares
`timescale 1ns / 1ps
module dsc_checker import dsc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  dsc_item_if.sink      in_if,
  dsc_result_if.sink    out_if,
  input  logic          irq_shared_i,
  output int            fail_count_o,
  output int            pending_count_o
);

  localparam int EXP_DEPTH = 8;

  logic [7:0] wr [2][17];
  logic [7:0] rr [2][16];
  logic [7:0] fifo [2][RX_FIFO_DEPTH];
  int unsigned rx_cnt [2];
  logic [2:0] pend [2];
  logic       enh [2];
  logic [3:0] ptr;
  logic [7:0] mic;
  logic [7:0] ivec;
  logic       tx_f;
  logic [7:0] tx_v;
  logic       tx_c;
  res_t       exp_mem [EXP_DEPTH];
  int         exp_head;
  int         exp_tail;
  int         fails;

  assign fail_count_o    = fails;
  assign pending_count_o = exp_tail - exp_head;

  function automatic void ch_reset(int c, bit hw);
    rx_cnt[c] = 0;
    pend[c]   = 3'b100;
    wr[c][0]  = 8'h00;
    wr[c][1]  &= 8'h24;
    wr[c][3]  &= 8'hFE;
    wr[c][4]  |= 8'h04;
    wr[c][5]  &= 8'h61;
    wr[c][15] = 8'hF8;
    rr[c][0]  = (rr[c][0] & 8'h38) | 8'h44;
    rr[c][1]  = 8'h07;
    rr[c][3]  = 8'h00;
    rr[c][10] = 8'h00;
    if (hw) begin
      wr[c][9]  = (wr[c][9] & 8'h03) | 8'hC0;
      wr[c][10] = 8'h00;
      wr[c][11] = 8'h08;
      wr[c][14] &= 8'hC0;
    end else begin
      wr[c][9]  &= 8'hDF;
      wr[c][10] &= 8'h60;
      wr[c][14] &= 8'hC3;
    end
    wr[c][14] |= 8'h20;
  endfunction

  function automatic void reset_all();
    mic = (mic & 8'h03) | 8'hC0;
    ptr = RP_CMD;
    ch_reset(0, 1'b1);
    ch_reset(1, 1'b1);
  endfunction

  function automatic logic [2:0] irq_pending(int c);
    logic [2:0] b;
    logic [1:0] mode;
    bit special, have;
    mode    = wr[c][1][4:3];
    special = rr[c][1][6:4] != 3'd0;
    have    = rx_cnt[c] != 0;
    b[0] = pend[c][PF_EXT] & wr[c][1][0];
    b[1] = pend[c][PF_TX] & wr[c][1][1] & wr[c][5][3];
    b[2] = wr[c][3][0] & ((special && mode != 2'b00) ||
           (have && (mode == 2'b10 || (mode == 2'b01 && pend[c][PF_ARM]))));
    return b;
  endfunction

  function automatic void load_tx(int c, logic [7:0] v);
    wr[c][8] = v;
    tx_f = 1'b1;
    tx_v = v;
    tx_c = c[0];
    pend[c][PF_TX] = 1'b0;
    rr[c][0][2] = 1'b0;
    rr[c][1][0] = 1'b0;
  endfunction

  function automatic logic [7:0] take_rx(int c);
    logic [7:0] v;
    v = 8'h00;
    if (rx_cnt[c] > 0) begin
      v = fifo[c][0];
      for (int i = 0; i < RX_FIFO_DEPTH - 1; i++) fifo[c][i] = fifo[c][i+1];
      rx_cnt[c]--;
    end
    rr[c][0][0] = 1'b0;
    rr[c][8] = v;
    pend[c][PF_ARM] = 1'b0;
    return v;
  endfunction

  function automatic void write_chan_reg(int c, int p, logic [7:0] v);
    logic [7:0] cur;
    if (p == 7 && wr[c][15][0]) p = 16;
    case (p)
      1: begin
        if (v[1] && !wr[c][1][1] && rr[c][0][2]) pend[c][PF_TX] = 1'b1;
        if ((v ^ wr[c][1]) & 8'h18) pend[c][PF_ARM] = 1'b1;
      end
      3: begin
        cur = wr[c][3];
        if ((cur ^ v) & 8'h10) begin
          cur |= 8'h10;
          rr[c][0] |= 8'h10;
        end
        if ((cur ^ v) & 8'h01) begin
          if (v[0]) cur |= 8'h01;
          else begin
            cur = (cur & 8'hFE) | 8'h10;
            rr[c][0] |= 8'h10;
          end
        end
        wr[c][3] = (cur & 8'h11) | (v & 8'hEE);
        return;
      end
      4: if ((v & 8'h0C) == 0 && (v & 8'h30) == 8'h20 && !wr[c][3][0]) rr[c][0] |= 8'h10;
      8: begin
        load_tx(c, v);
        return;
      end
      default: ;
    endcase
    wr[c][p] = v;
  endfunction

  function automatic void command_write(int c, logic [7:0] v);
    logic [3:0] p;
    p = ptr;
    if (p == RP_CMD) begin
      ptr = {1'b0, v[2:0]};
      case (v[5:3])
        CMD_POINT_HIGH: ptr[3] = 1'b1;
        CMD_RESET_EXT:  pend[c][PF_EXT] = 1'b0;
        CMD_ARM_RX:     pend[c][PF_ARM] = 1'b1;
        CMD_RESET_TX:   pend[c][PF_TX] = 1'b0;
        CMD_ERR_RESET:  rr[c][1] &= 8'h8F;
        default: ;
      endcase
      return;
    end
    if (p == RP_IVEC) ivec = v;
    else if (p == RP_MIC) begin
      case (v[7:6])
        RST_CH_B: ch_reset(1, 1'b0);
        RST_CH_A: ch_reset(0, 1'b0);
        RST_HW:   reset_all();
        default: ;
      endcase
      mic = v & 8'h3F;
    end else write_chan_reg(c, int'(p), v);
    ptr = RP_CMD;
  endfunction

  function automatic logic [7:0] command_read(int c);
    logic [3:0] p;
    logic [7:0] v;
    p = ptr;
    ptr = RP_CMD;
    if (p == RP_3) v = (c == 0) ? {2'b00, irq_pending(0), irq_pending(1)} : 8'h00;
    else if (p == RP_IVEC) v = ivec;
    else if (p == RP_CMD) begin
      rr[c][0][0] = wr[c][3][0] && rx_cnt[c] != 0;
      v = rr[c][0];
    end else if (p == RP_DATA) v = take_rx(c);
    else v = rr[c][p];
    return v;
  endfunction

  function automatic res_t predict(dsc_tb_pkg::stim_t it);
    res_t r;
    int ch;
    logic [7:0] lines;
    bit a, b;
    ch = it.channel;
    r.read_data = 8'h00;
    tx_f = 1'b0; tx_v = 8'h00; tx_c = 1'b0;
    case (it.kind)
      KIND_READ: case (it.port)
        PORT_CMD_B:  r.read_data = command_read(1);
        PORT_CMD_A:  r.read_data = command_read(0);
        PORT_DATA_B: r.read_data = take_rx(1);
        PORT_DATA_A: r.read_data = take_rx(0);
        PORT_ENH_B:  r.read_data = {3'b000, enh[1], 4'h0};
        PORT_ENH_A:  r.read_data = {3'b000, enh[0], 4'h0};
        default: ;
      endcase
      KIND_WRITE: case (it.port)
        PORT_CMD_B:  command_write(1, it.data_in);
        PORT_CMD_A:  command_write(0, it.data_in);
        PORT_DATA_B: load_tx(1, it.data_in);
        PORT_DATA_A: load_tx(0, it.data_in);
        PORT_ENH_B:  enh[1] = it.data_in[4];
        PORT_ENH_A:  enh[0] = it.data_in[4];
        default: ;
      endcase
      KIND_RX: if (wr[ch][3][0]) begin
        if (rx_cnt[ch] < RX_FIFO_DEPTH) begin
          fifo[ch][rx_cnt[ch]] = it.data_in;
          rx_cnt[ch]++;
        end else rr[ch][1] |= 8'h20;
      end
      KIND_TX_DONE: if (!rr[ch][0][2]) begin
        rr[ch][0] |= 8'h04;
        rr[ch][1] |= 8'h01;
        pend[ch][PF_TX] = 1'b1;
      end
      KIND_MODEM: begin
        lines = it.line_connected ? 8'h28 : 8'h00;
        if ((rr[ch][0] ^ lines) & wr[ch][15] & 8'h28) pend[ch][PF_EXT] = 1'b1;
        rr[ch][0] = (rr[ch][0] & 8'hD7) | lines;
      end
      default: ;
    endcase
    a = mic[3] && irq_pending(0) != 0;
    b = mic[3] && irq_pending(1) != 0;
    r.irq_line_a   = irq_shared_i ? (a || b) : a;
    r.irq_line_b   = irq_shared_i ? 1'b0 : b;
    r.tx_strobe    = tx_f;
    r.tx_byte      = tx_v;
    r.tx_channel   = tx_c;
    r.rx_enabled_a = wr[0][3][0];
    r.rx_enabled_b = wr[1][3][0];
    return r;
  endfunction

  initial begin
    fails = 0;
    exp_head = 0;
    exp_tail = 0;
    ptr = '0; mic = '0; ivec = '0;
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < 17; i++) wr[c][i] = '0;
      for (int i = 0; i < 16; i++) rr[c][i] = '0;
      for (int i = 0; i < RX_FIFO_DEPTH; i++) fifo[c][i] = '0;
      rx_cnt[c] = 0;
      enh[c] = 1'b0;
    end
    reset_all();
  end

  always @(posedge clk_i) begin
    res_t got, exp_r;
    dsc_tb_pkg::stim_t it;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.read_data, out_if.irq_line_a, out_if.irq_line_b, out_if.tx_strobe,
                out_if.tx_byte, out_if.tx_channel, out_if.rx_enabled_a, out_if.rx_enabled_b};
        if (exp_tail == exp_head) begin
          fails++;
          if (fails <= 10) $display("unexpected result transaction %h", got);
        end else begin
          exp_r = exp_mem[exp_head % EXP_DEPTH];
          exp_head++;
          if (got !== exp_r) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %h actual %h", exp_r, got);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        it = '{in_if.kind, in_if.port, in_if.channel, in_if.data_in, in_if.line_connected};
        if (exp_tail - exp_head >= EXP_DEPTH) begin
          fails++;
          if (fails <= 10) $display("too many transactions in flight");
        end else begin
          exp_mem[exp_tail % EXP_DEPTH] = predict(it);
          exp_tail++;
        end
      end
    end
  end

endmodule

FILE: tb/testbench.sv
// testbench top: clock, reset, stimulus, apb configuration and verdict
`timescale 1ns / 1ps
module testbench import dsc_pkg::*;;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        irq_shared = 1'b0;
  int          fail_count, pending_count;
  int          cycles = 0;
  bit          calm = 1'b0;
  int          out_gap = 0;

  dsc_item_if   in_if ();
  dsc_result_if out_if ();

  dual_serial_controller_regs dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if.sink), .out_if(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dsc_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if.sink), .out_if(out_if.sink),
    .irq_shared_i(irq_shared), .fail_count_o(fail_count), .pending_count_o(pending_count)
  );

  always #1 clk_i = ~clk_i;

  // cycle limit: ends the run as failed, with room for every item plus stalls
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result sink drops ready in random bursts outside the calm tail
  always @(negedge clk_i) begin
    if (calm) out_if.ready <= 1'b1;
    else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(0, 8);
      out_if.ready <= 1'b0;
    end else out_if.ready <= 1'b1;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = '0;
    in_if.port = '0;
    in_if.channel = 1'b0;
    in_if.data_in = '0;
    in_if.line_connected = 1'b0;
    out_if.ready = 1'b0;
  end

  // one apb write in setup and access cycles
  task automatic apb_write(logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 3'(4 * CFG_IRQ_SHARED); pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    irq_shared <= value[0];
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // send one transaction, idling first at random outside the calm tail
  task automatic send(logic [2:0] k, logic [2:0] p, logic c, logic [7:0] d, logic l);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 9);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= k;
    in_if.port <= p;
    in_if.channel <= c;
    in_if.data_in <= d;
    in_if.line_connected <= l;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] p, logic [3:0] r, logic [7:0] v);
    if (r > 7) send(KIND_WRITE, p, 1'b0, {2'b00, CMD_POINT_HIGH, r[2:0]}, 1'b0);
    else send(KIND_WRITE, p, 1'b0, {5'b0, r[2:0]}, 1'b0);
    send(KIND_WRITE, p, 1'b0, v, 1'b0);
  endtask

  task automatic reg_read(logic [2:0] p, logic [3:0] r);
    if (r > 7) send(KIND_WRITE, p, 1'b0, {2'b00, CMD_POINT_HIGH, r[2:0]}, 1'b0);
    else send(KIND_WRITE, p, 1'b0, {5'b0, r[2:0]}, 1'b0);
    send(KIND_READ, p, 1'b0, 8'($urandom_range(0, 255)), 1'b0);
  endtask

  // stop offering items and wait until every result is taken
  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // random mix, mostly well-formed pointer sequences on the command ports
  task automatic random_phase(int n);
    int sel;
    logic [2:0] cp;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      cp = $urandom_range(0, 1) ? PORT_CMD_A : PORT_CMD_B;
      if (sel < 25) reg_write(cp, 4'($urandom_range(0, 15)),
                              ($urandom_range(0, 3) == 0) ? 8'(8'h09 | $urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 255)));
      else if (sel < 40) reg_read(cp, 4'($urandom_range(0, 15)));
      else if (sel < 45) send(KIND_WRITE, cp, 1'b0, 8'($urandom_range(0, 255)), 1'b0);
      else if (sel < 60) send(KIND_RX, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (sel < 70) send(KIND_READ, 3'($urandom_range(2, 7)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (sel < 77) send(KIND_WRITE, 3'($urandom_range(2, 7)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (sel < 85) send(KIND_TX_DONE, 3'($urandom_range(0, 7)),
                              1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
      else if (sel < 95) send(KIND_MODEM, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else send(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    apb_write(32'd0);
    // directed: enable receivers and interrupts, fill fifo past full, read it back
    reg_write(PORT_CMD_A, RP_3, 8'hFF);
    reg_write(PORT_CMD_B, RP_3, 8'h01);
    reg_write(PORT_CMD_A, RP_1, 8'h13);
    reg_write(PORT_CMD_A, RP_MIC, 8'h08);
    for (int i = 0; i < 4; i++) send(KIND_RX, 3'd7, 1'b0, 8'(i * 85), 1'b1);
    reg_read(PORT_CMD_A, RP_1);
    for (int i = 0; i < 4; i++) send(KIND_READ, PORT_DATA_A, 1'b0, 8'h00, 1'b0);
    send(KIND_TX_DONE, 3'd0, 1'b1, 8'hFF, 1'b0);
    send(KIND_TX_DONE, 3'd0, 1'b1, 8'h00, 1'b0);
    send(KIND_MODEM, 3'd0, 1'b0, 8'h00, 1'b1);
    send(KIND_WRITE, PORT_ENH_A, 1'b0, 8'hFF, 1'b0);
    send(KIND_READ, PORT_ENH_A, 1'b0, 8'h00, 1'b0);
    send(KIND_WRITE, 3'd6, 1'b0, 8'hAA, 1'b0);
    send(KIND_READ, 3'd7, 1'b0, 8'h55, 1'b0);
    send(3'd7, 3'd7, 1'b1, 8'hFF, 1'b1);
    drain();
    apb_write(32'd1);
    random_phase(450);
    drain();
    apb_write(32'd0);
    random_phase(450);
    drain();
    apb_write(32'hFFFF_FFFF);
    random_phase(300);
    calm = 1'b1;
    random_phase(150);
    drain();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
